// ----- design/fr_pkg.sv -----
package fr_pkg;

  localparam int unsigned FieldBits   = 31;
  localparam int unsigned InWordBits  = 64;
  localparam int unsigned OutWordBits = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EU_CHECK,
    ST_EU_WAIT,
    ST_NUM_START,
    ST_NUM_WAIT,
    ST_DEN_START,
    ST_DEN_WAIT,
    ST_DONE
  } fr_state_e;

endpackage

// ----- design/fr_div.sv -----
module fr_div #(
  parameter int unsigned DATA_BITS = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DATA_BITS-1:0] dividend_i,
  input  logic [DATA_BITS-1:0] divisor_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [DATA_BITS-1:0] quot_o,
  output logic [DATA_BITS-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(DATA_BITS + 1);

  logic [DATA_BITS-1:0] rem_q, rem_d;
  logic [DATA_BITS-1:0] quo_q, quo_d;
  logic [DATA_BITS-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DATA_BITS:0]   shifted;
  logic [DATA_BITS+1:0] diff;

  assign shifted = {rem_q, quo_q[DATA_BITS-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      if (!diff[DATA_BITS+1]) begin
        rem_d = diff[DATA_BITS-1:0];
        quo_d = {quo_q[DATA_BITS-2:0], 1'b1};
      end else begin
        rem_d = shifted[DATA_BITS-1:0];
        quo_d = {quo_q[DATA_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(DATA_BITS);
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

`ifndef NO_ASSERTIONS
  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");
  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a finished run");
  a_rem_below_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < dvs_q)
    else $error("divider remainder not below divisor");
`endif

endmodule

// ----- design/fraction_reduce_gcd_core.sv -----
// Reduces a fraction to lowest terms. Each word on s_axis carries a numerator and a
// denominator; the block finds their greatest common divisor with Euclid's remainder
// loop and returns both divided by it as one word on m_axis. One shared restoring
// divider, one quotient bit per cycle, does every remainder step and the two final
// divisions. Zero over nonzero gives 0/1, nonzero over zero gives 1/0, and zero
// over zero sets zero_error with zero data. Input bits above DATA_BITS are
// ignored. One item is worked on at a time; a finished word waits in an output
// register while the next word is taken.
module fraction_reduce_gcd_core
  import fr_pkg::*;
#(
  parameter int unsigned DATA_BITS = 31
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [InWordBits-1:0]  s_axis_tdata,  // num_in, den_in, zero pad
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OutWordBits-1:0] m_axis_tdata,  // num_out, den_out, zero pad
  output logic                   m_axis_tuser   // zero_error
);

  fr_state_e state_q, state_d;

  logic [DATA_BITS-1:0] in_num, in_den;
  logic                 in_zero;
  logic                 s_fire;
  logic [DATA_BITS-1:0] a_q, b_q, num_q, den_q, res_num_q, res_den_q;
  logic                 err_q;
  logic                 div_start, div_busy, div_done;
  logic [DATA_BITS-1:0] div_dividend, div_divisor, div_quot, div_rem;
  logic                 out_load;
  logic                 out_valid_q;
  logic [FieldBits-1:0] out_num_q, out_den_q;
  logic                 out_err_q;

  assign in_num  = DATA_BITS'(s_axis_tdata[FieldBits-1:0]);
  assign in_den  = DATA_BITS'(s_axis_tdata[2*FieldBits-1:FieldBits]);
  assign in_zero = (in_num == '0) && (in_den == '0);
  assign s_fire  = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = in_zero ? ST_DONE : ST_EU_CHECK;
      end
      ST_EU_CHECK:  state_d = (b_q == '0) ? ST_NUM_START : ST_EU_WAIT;
      ST_EU_WAIT: begin
        if (div_done) state_d = ST_EU_CHECK;
      end
      ST_NUM_START: state_d = ST_NUM_WAIT;
      ST_NUM_WAIT: begin
        if (div_done) state_d = ST_DEN_START;
      end
      ST_DEN_START: state_d = ST_DEN_WAIT;
      ST_DEN_WAIT: begin
        if (div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    div_dividend  = a_q;
    div_divisor   = b_q;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE:      s_axis_tready = 1'b1;
      ST_EU_CHECK:  div_start = (b_q != '0);
      ST_NUM_START: begin
        div_start    = 1'b1;
        div_dividend = num_q;
        div_divisor  = a_q;
      end
      ST_DEN_START: begin
        div_start    = 1'b1;
        div_dividend = den_q;
        div_divisor  = a_q;
      end
      ST_DONE:      out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      a_q       <= in_num;
      b_q       <= in_den;
      num_q     <= in_num;
      den_q     <= in_den;
      err_q     <= in_zero;
      res_num_q <= '0;
      res_den_q <= '0;
    end
    if (state_q == ST_EU_WAIT && div_done) begin
      a_q <= b_q;
      b_q <= div_rem;
    end
    if (state_q == ST_NUM_WAIT && div_done) res_num_q <= div_quot;
    if (state_q == ST_DEN_WAIT && div_done) res_den_q <= div_quot;
    if (out_load) begin
      out_num_q <= FieldBits'(res_num_q);
      out_den_q <= FieldBits'(res_den_q);
      out_err_q <= err_q;
    end
  end

  fr_div #(
    .DATA_BITS(DATA_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutWordBits - 2*FieldBits){1'b0}}, out_den_q, out_num_q};
  assign m_axis_tuser  = out_err_q;

`ifndef NO_ASSERTIONS
  a_err_zero_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> out_num_q == '0 && out_den_q == '0)
    else $error("zero_error word carries nonzero data");
  a_ok_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> out_num_q != '0 || out_den_q != '0)
    else $error("reduced fraction is zero over zero");
  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> div_divisor != '0 && !div_busy)
    else $error("division by zero or while busy");
  a_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_EU_WAIT || state_q == ST_NUM_WAIT ||
                 state_q == ST_DEN_WAIT)
    else $error("divider finished outside a wait state");
`endif

endmodule
